/* rtl/core/hcbp_pkg.sv */
package hcbp_pkg;

  localparam int SYMBOLS      = 256;
  localparam int ADDR_W       = $clog2(SYMBOLS);
  localparam int MAX_CODE_LEN = 32;
  localparam int CODE_W       = 32;
  localparam int LEN_W        = 6;
  localparam int MAX_BYTES    = 4;
  localparam int BCNT_W       = 3;
  localparam int WIN_W        = CODE_W + 8;

  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_ENCODE = 2'd1,
    REQ_FLUSH  = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  // code word is stored MSB-aligned, bits below the length are zero
  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } entry_t;

  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [BCNT_W-1:0]         cnt;
  } burst_t;

endpackage

/* rtl/core/hcbp_table.sv */
module hcbp_table (
  input  logic                       clk,
  input  logic                       we,
  input  logic [hcbp_pkg::ADDR_W-1:0] waddr,
  input  hcbp_pkg::entry_t           wdata,
  input  logic                       re,
  input  logic [hcbp_pkg::ADDR_W-1:0] raddr,
  output hcbp_pkg::entry_t           rdata
);

  hcbp_pkg::entry_t mem [hcbp_pkg::SYMBOLS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/hcbp_pack.sv */
module hcbp_pack (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  hcbp_pkg::req_t     in_kind,
  output logic               in_ready,
  input  hcbp_pkg::entry_t   entry,
  input  logic               ob_free,
  output logic               push,
  output hcbp_pkg::burst_t   burst
);

  logic                         s1_valid;
  hcbp_pkg::req_t               s1_kind;
  logic [6:0]                   pbits;
  logic [2:0]                   pcount;
  logic [6:0]                   pbits_next;
  logic [2:0]                   pcount_next;
  logic [7:0]                   p8;
  logic [hcbp_pkg::WIN_W-1:0]   win;
  logic [hcbp_pkg::WIN_W-1:0]   win_sh;
  logic [hcbp_pkg::LEN_W-1:0]   total;
  logic [hcbp_pkg::BCNT_W-1:0]  nbytes;

  assign in_ready = !s1_valid || ob_free;
  assign push     = s1_valid && ob_free;

  // pending bits are held left-aligned, unused low bits zero
  always_comb begin
    p8     = {pbits, 1'b0};
    win    = {p8, hcbp_pkg::CODE_W'(0)} | ({entry.code, 8'b0} >> pcount);
    total  = hcbp_pkg::LEN_W'(pcount) + entry.len;
    nbytes = hcbp_pkg::BCNT_W'(total >> 3);
    win_sh = win << {nbytes, 3'b000};
    burst  = '0;
    pbits_next  = '0;
    pcount_next = '0;
    case (s1_kind)
      hcbp_pkg::REQ_ENCODE: begin
        for (int k = 0; k < hcbp_pkg::MAX_BYTES; k++) begin
          burst.bytes[k] = win[hcbp_pkg::WIN_W-1-8*k -: 8];
        end
        burst.cnt   = nbytes;
        pbits_next  = win_sh[hcbp_pkg::WIN_W-1 -: 7];
        pcount_next = total[2:0];
      end
      hcbp_pkg::REQ_FLUSH: begin
        burst.bytes[0] = p8;
        burst.cnt      = (pcount != 3'd0) ? hcbp_pkg::BCNT_W'(1) : '0;
      end
      default: begin
        pbits_next  = pbits;
        pcount_next = pcount;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_kind  <= hcbp_pkg::REQ_NONE;
      pbits    <= '0;
      pcount   <= '0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
        s1_kind  <= in_kind;
      end
      if (push) begin
        pbits  <= pbits_next;
        pcount <= pcount_next;
      end
    end
  end

endmodule

/* rtl/core/hcbp_obuf.sv */
module hcbp_obuf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  hcbp_pkg::burst_t burst,
  output logic             ob_free,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             out_last
);

  logic [hcbp_pkg::MAX_BYTES-1:0][7:0] q;
  logic [hcbp_pkg::BCNT_W-1:0]         cnt;

  assign out_valid = cnt != '0;
  assign out_byte  = q[0];
  assign out_last  = cnt == hcbp_pkg::BCNT_W'(1);
  assign ob_free   = (cnt == '0) || (out_last && out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (push) begin
      cnt <= burst.cnt;
    end else if (out_valid && out_ready) begin
      cnt <= cnt - hcbp_pkg::BCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q <= burst.bytes;
    end else if (out_valid && out_ready) begin
      q <= q >> 8;
    end
  end

endmodule

/* rtl/core/huffman_code_bit_packer.sv */
// Huffman code bit packer.
// Slave channel: one request per beat. tuser carries the request kind
// (load entry, encode symbol, flush); tdata carries symbol, code word and
// code length. Load beats write the 256-entry code table and produce nothing.
// Encode beats append the symbol's code MSB-first to the bit accumulator and
// emit every completed byte; flush pads the leftover bits with zeros and
// emits them as a final byte if any are left. Each master beat is one byte;
// tlast marks the last byte caused by a request. A request's bytes pass the
// table read, the pack stage and the output buffer in turn. Throughput is
// one request per cycle while each request yields at most one byte and the
// receiver is ready; a request yielding more bytes holds the master channel
// until all are taken, and the pack stage waits until the output buffer
// drains to its last byte, set by the single-byte output port.
// When the receiver stalls, the output buffer holds, then the pack stage,
// then tready drops. Reset empties the accumulator and the pipeline; the
// table keeps no reset value and must be loaded before a symbol is encoded.
module huffman_code_bit_packer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // symbol[7:0], code_bits[39:8], code_len[45:40]
  input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // out_byte[7:0]
  output logic        m_axis_tlast
);

  hcbp_pkg::req_t                   req;
  logic [7:0]                       symbol;
  logic [hcbp_pkg::CODE_W-1:0]      code_bits;
  logic [hcbp_pkg::LEN_W-1:0]       code_len;
  logic [hcbp_pkg::LEN_W-1:0]       len_sat;
  logic                             accept;
  logic                             in_range;
  logic                             tbl_we;
  logic                             tbl_re;
  hcbp_pkg::entry_t                 wentry;
  hcbp_pkg::entry_t                 rentry;
  logic                             s1_in;
  logic                             ob_free;
  logic                             push;
  hcbp_pkg::burst_t                 burst;

  assign req       = hcbp_pkg::req_t'(s_axis_tuser);
  assign symbol    = s_axis_tdata[7:0];
  assign code_bits = s_axis_tdata[39:8];
  assign code_len  = s_axis_tdata[45:40];
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign in_range  = {1'b0, symbol} < 9'(hcbp_pkg::SYMBOLS);
  assign len_sat   = (code_len > hcbp_pkg::LEN_W'(hcbp_pkg::MAX_CODE_LEN))
                     ? hcbp_pkg::LEN_W'(hcbp_pkg::MAX_CODE_LEN) : code_len;

  always_comb begin
    wentry.len  = len_sat;
    wentry.code = code_bits << (hcbp_pkg::LEN_W'(hcbp_pkg::CODE_W) - len_sat);
  end

  assign tbl_we = accept && (req == hcbp_pkg::REQ_LOAD) && in_range;
  assign tbl_re = accept && (req == hcbp_pkg::REQ_ENCODE) && in_range;
  assign s1_in  = tbl_re || (accept && (req == hcbp_pkg::REQ_FLUSH));

  hcbp_table u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (symbol[hcbp_pkg::ADDR_W-1:0]),
    .wdata (wentry),
    .re    (tbl_re),
    .raddr (symbol[hcbp_pkg::ADDR_W-1:0]),
    .rdata (rentry)
  );

  hcbp_pack u_pack (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s1_in),
    .in_kind  (req),
    .in_ready (s_axis_tready),
    .entry    (rentry),
    .ob_free  (ob_free),
    .push     (push),
    .burst    (burst)
  );

  hcbp_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .burst     (burst),
    .ob_free   (ob_free),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_byte  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

  a_burst_fits: assert property (@(posedge clk) disable iff (rst)
    push |-> (burst.cnt <= hcbp_pkg::BCNT_W'(hcbp_pkg::MAX_BYTES)))
    else $error("burst larger than output buffer");

  a_burst_shows: assert property (@(posedge clk) disable iff (rst)
    (push && (burst.cnt != '0)) |=> m_axis_tvalid)
    else $error("pushed bytes not presented");

  a_push_free: assert property (@(posedge clk) disable iff (rst)
    push |-> ob_free)
    else $error("push into busy output buffer");

  a_port_excl: assert property (@(posedge clk) disable iff (rst)
    !(tbl_we && tbl_re))
    else $error("table read and write in the same beat");

endmodule
